// File: src/pgalloc_pkg.sv
// ----------------------------------------------------------------------------
// pgalloc_pkg
// Shared types and constants for the page allocator with reference counts.
// ----------------------------------------------------------------------------
package pgalloc_pkg;

  // default sizing
  localparam int unsigned NUM_PAGES_DEF  = 65536;
  localparam int unsigned COUNT_BITS_DEF = 8;

  // fixed field widths
  localparam int unsigned OP_W     = 3;
  localparam int unsigned PAGE_W   = 16;
  localparam int unsigned STS_W    = 3;
  localparam int unsigned REFOUT_W = 8;
  localparam int unsigned FREE_W   = 17;

  // stream and register port widths
  localparam int unsigned S_DATA_W = 24;
  localparam int unsigned M_DATA_W = 48;
  localparam int unsigned CFG_AW   = 3;
  localparam int unsigned CFG_DW   = 32;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 3'd0,
    OP_FREE  = 3'd1,
    OP_SEED  = 3'd2,
    OP_INCR  = 3'd3,
    OP_DECR  = 3'd4,
    OP_READ  = 3'd5
  } op_e;

  // result status codes
  typedef enum logic [STS_W-1:0] {
    STS_OK    = 3'd0,
    STS_EMPTY = 3'd1,
    STS_BAD   = 3'd2,
    STS_FULL  = 3'd3,
    STS_LIMIT = 3'd4
  } status_e;

  // controller states
  typedef enum logic [1:0] {
    CLEAR_S = 2'd0,
    IDLE_S  = 2'd1,
    EXEC_S  = 2'd2
  } fsm_e;

  // controller to datapath
  typedef struct packed {
    logic clear_step;
    logic load;
    logic commit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic out_free;
  } dp_sts_t;

endpackage

// File: src/pgalloc_ram.sv
// ----------------------------------------------------------------------------
// pgalloc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pgalloc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/pgalloc_ctrl.sv
// ----------------------------------------------------------------------------
// pgalloc_ctrl
// Controller: count clearing pass, word intake and commit sequencing.
// ----------------------------------------------------------------------------
module pgalloc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  input  pgalloc_pkg::dp_sts_t sts_i,
  output pgalloc_pkg::dp_cmd_t cmd_o
);
  import pgalloc_pkg::*;

  fsm_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CLEAR_S;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CLEAR_S: begin
        if (sts_i.clear_last) state_d = IDLE_S;
      end
      IDLE_S: begin
        if (s_tvalid_i) state_d = EXEC_S;
      end
      EXEC_S: begin
        if (sts_i.out_free) state_d = IDLE_S;
      end
      default: state_d = CLEAR_S;
    endcase
  end

  // outputs
  always_comb begin
    s_tready_o       = 1'b0;
    cmd_o.clear_step = 1'b0;
    cmd_o.load       = 1'b0;
    cmd_o.commit     = 1'b0;
    unique case (state_q)
      CLEAR_S: begin
        cmd_o.clear_step = 1'b1;
      end
      IDLE_S: begin
        s_tready_o = 1'b1;
        cmd_o.load = s_tvalid_i;
      end
      EXEC_S: begin
        cmd_o.commit = sts_i.out_free;
      end
      default: begin
        s_tready_o = 1'b0;
      end
    endcase
  end

  // checks
  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.clear_step, cmd_o.load, cmd_o.commit}))
    else $error("controller issued overlapping commands");

  a_exec_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == EXEC_S) |-> ($past(cmd_o.load) || $past(state_q == EXEC_S)))
    else $error("execute state entered without a loaded word");

  a_no_intake_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CLEAR_S) |=> !$past(s_tready_o))
    else $error("input taken during clearing pass");

endmodule

// File: src/pgalloc_dp.sv
// ----------------------------------------------------------------------------
// pgalloc_dp
// Datapath: count and stack memories, stack top, operation logic, output word.
// ----------------------------------------------------------------------------
module pgalloc_dp #(
  parameter int unsigned NUM_PAGES  = pgalloc_pkg::NUM_PAGES_DEF,
  parameter int unsigned COUNT_BITS = pgalloc_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pgalloc_pkg::dp_cmd_t                cmd_i,
  output pgalloc_pkg::dp_sts_t                sts_o,
  input  logic [pgalloc_pkg::OP_W-1:0]        in_op_i,
  input  logic [pgalloc_pkg::PAGE_W-1:0]      in_page_i,
  input  logic [pgalloc_pkg::PAGE_W-1:0]      lowest_page_i,
  input  logic                                m_tready_i,
  output logic                                m_tvalid_o,
  // m_tdata_o: status, page_out, ref_count, free_pages, zero fill
  output logic [pgalloc_pkg::M_DATA_W-1:0]    m_tdata_o
);
  import pgalloc_pkg::*;

  localparam int unsigned AW = $clog2(NUM_PAGES);
  localparam int unsigned TW = $clog2(NUM_PAGES + 1);
  localparam int unsigned CW = COUNT_BITS;
  localparam logic [31:0]   NumPagesW = 32'(NUM_PAGES);
  localparam logic [TW-1:0] TopFull   = TW'(NUM_PAGES);
  localparam logic [AW-1:0] LastAddr  = AW'(NUM_PAGES - 1);
  localparam logic [CW-1:0] CountMax  = {CW{1'b1}};
  localparam logic [CW-1:0] CountOne  = CW'(1);

  // state
  logic [AW-1:0]     clr_cnt_q;
  logic [TW-1:0]     stack_top_q, stack_top_d;
  op_e               op_q;
  logic [PAGE_W-1:0] page_q;
  logic              m_tvalid_q;
  logic [M_DATA_W-1:0] m_tdata_q;

  // memory ports
  logic [CW-1:0]     cnt_rd;
  logic [PAGE_W-1:0] stk_rd;
  logic              cnt_we;
  logic [AW-1:0]     cnt_waddr;
  logic [CW-1:0]     cnt_wdata;

  // operation results
  status_e           sts;
  logic [PAGE_W-1:0] pg_res;
  logic [CW-1:0]     cnt_res;
  logic [CW-1:0]     cnt_new;
  logic              cnt_upd;
  logic              push;
  logic              pop;
  logic              in_range;
  logic              below_low;
  logic [CW-1:0]     base;
  logic [CW-1:0]     dec;

  // clearing pass counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear_step) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  // input word capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_e'(in_op_i);
      page_q <= in_page_i;
    end
  end

  // per-page counts
  pgalloc_ram #(
    .WIDTH (CW),
    .DEPTH (NUM_PAGES)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (cmd_i.load),
    .raddr_i (AW'(in_page_i)),
    .rdata_o (cnt_rd)
  );

  // free page stack
  pgalloc_ram #(
    .WIDTH (PAGE_W),
    .DEPTH (NUM_PAGES)
  ) u_stk_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit & push),
    .waddr_i (AW'(stack_top_q)),
    .wdata_i (page_q),
    .re_i    (cmd_i.load),
    .raddr_i (AW'(stack_top_q - TW'(1))),
    .rdata_o (stk_rd)
  );

  assign in_range  = 32'(page_q) < NumPagesW;
  assign below_low = page_q < lowest_page_i;
  assign base      = (op_q == OP_SEED) ? '0 : cnt_rd;
  assign dec       = (base != '0) ? base - CountOne : base;

  // operation logic
  always_comb begin
    sts     = STS_OK;
    pg_res  = page_q;
    cnt_res = '0;
    cnt_new = cnt_rd;
    cnt_upd = 1'b0;
    push    = 1'b0;
    pop     = 1'b0;
    unique case (op_q)
      OP_ALLOC: begin
        if (stack_top_q == '0) begin
          sts    = STS_EMPTY;
          pg_res = '0;
        end else begin
          pop     = 1'b1;
          pg_res  = stk_rd;
          cnt_new = CountOne;
          cnt_upd = 1'b1;
          cnt_res = CountOne;
        end
      end
      OP_FREE, OP_SEED: begin
        if (!in_range || below_low) begin
          sts = STS_BAD;
        end else begin
          cnt_new = dec;
          cnt_upd = 1'b1;
          cnt_res = dec;
          if (dec == '0) begin
            if (stack_top_q == TopFull) sts = STS_FULL;
            else push = 1'b1;
          end
        end
      end
      OP_INCR: begin
        if (!in_range) begin
          sts = STS_BAD;
        end else if (cnt_rd == CountMax) begin
          sts     = STS_LIMIT;
          cnt_res = cnt_rd;
        end else begin
          cnt_new = cnt_rd + CountOne;
          cnt_upd = 1'b1;
          cnt_res = cnt_new;
        end
      end
      OP_DECR: begin
        if (!in_range) begin
          sts = STS_BAD;
        end else if (cnt_rd == '0) begin
          sts     = STS_LIMIT;
          cnt_res = cnt_rd;
        end else begin
          cnt_new = cnt_rd - CountOne;
          cnt_upd = 1'b1;
          cnt_res = cnt_new;
        end
      end
      // read, and the unused codes
      default: begin
        if (!in_range) sts = STS_BAD;
        else cnt_res = cnt_rd;
      end
    endcase
  end

  // count memory write: clearing pass or commit
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = AW'(page_q);
    cnt_wdata = cnt_new;
    priority if (cmd_i.clear_step) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_cnt_q;
      cnt_wdata = '0;
    end else if (cmd_i.commit && cnt_upd) begin
      cnt_we    = 1'b1;
      cnt_waddr = pop ? AW'(stk_rd) : AW'(page_q);
    end else begin
      cnt_we = 1'b0;
    end
  end

  // stack top
  always_comb begin
    stack_top_d = stack_top_q;
    priority if (cmd_i.commit && push) begin
      stack_top_d = stack_top_q + TW'(1);
    end else if (cmd_i.commit && pop) begin
      stack_top_d = stack_top_q - TW'(1);
    end else begin
      stack_top_d = stack_top_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stack_top_q <= '0;
    end else begin
      stack_top_q <= stack_top_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      m_tvalid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      m_tdata_q <= {4'b0, FREE_W'(stack_top_d), REFOUT_W'(cnt_res), pg_res, sts};
    end
  end

  assign m_tvalid_o       = m_tvalid_q;
  assign m_tdata_o        = m_tdata_q;
  assign sts_o.clear_last = cmd_i.clear_step && (clr_cnt_q == LastAddr);
  assign sts_o.out_free   = !m_tvalid_q || m_tready_i;

  // checks
  a_top_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stack_top_q <= TopFull)
    else $error("stack top beyond page count");

  a_push_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && push) |=> (stack_top_q == $past(stack_top_q) + TW'(1)))
    else $error("push did not advance stack top");

  a_pop_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && pop) |=> (stack_top_q == $past(stack_top_q) - TW'(1)))
    else $error("pop did not retire stack top");

  a_out_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid_q) |-> $past(cmd_i.commit))
    else $error("result word without a commit");

endmodule

// File: src/page_allocator_with_refcount_unit.sv
// ----------------------------------------------------------------------------
// page_allocator_with_refcount_unit
// Result path: an input word is captured along with its memory reads, then
// its result is registered at the output once no earlier result word still
// waits on m_axis_tready. No new word is taken until the last one commits,
// since the count and stack memories are read through registers before their write-back.
// Reset: a clearing pass zeroes the count memory, one page per cycle, through
// every page; s_axis_tready stays low meanwhile, register writes work.
// ----------------------------------------------------------------------------
module page_allocator_with_refcount_unit #(
  parameter int unsigned NUM_PAGES  = pgalloc_pkg::NUM_PAGES_DEF,
  parameter int unsigned COUNT_BITS = pgalloc_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // s_axis_tdata: operation [2:0], page_number [18:3], zero fill [23:19]
  input  logic [pgalloc_pkg::S_DATA_W-1:0]   s_axis_tdata,
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // m_axis_tdata: status [2:0], page_out [18:3], ref_count [26:19],
  // free_pages [43:27], zero fill [47:44]
  output logic [pgalloc_pkg::M_DATA_W-1:0]   m_axis_tdata,
  // register port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pgalloc_pkg::CFG_AW-1:0]     paddr,
  input  logic [pgalloc_pkg::CFG_DW-1:0]     pwdata,
  output logic [pgalloc_pkg::CFG_DW-1:0]     prdata,
  output logic                               pready
);
  import pgalloc_pkg::*;

  logic [PAGE_W-1:0] lowest_page_q;
  logic              sel_lowest;
  dp_cmd_t           cmd;
  dp_sts_t           sts;

  // register decode: lowest_page at word 0
  assign sel_lowest = (paddr[CFG_AW-1] == 1'b0);
  assign pready     = 1'b1;
  assign prdata     = sel_lowest ? CFG_DW'(lowest_page_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lowest_page_q <= '0;
    end else if (psel && penable && pwrite && pready && sel_lowest) begin
      lowest_page_q <= pwdata[PAGE_W-1:0];
    end
  end

  pgalloc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pgalloc_dp #(
    .NUM_PAGES  (NUM_PAGES),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_op_i       (s_axis_tdata[OP_W-1:0]),
    .in_page_i     (s_axis_tdata[OP_W+PAGE_W-1:OP_W]),
    .lowest_page_i (lowest_page_q),
    .m_tready_i    (m_axis_tready),
    .m_tvalid_o    (m_axis_tvalid),
    .m_tdata_o     (m_axis_tdata)
  );

endmodule
